// File: rtl/dnls_pkg.sv
// shared types, constants and register codes for the day/night light switch
package dnls_pkg;

  localparam int SAMPLES_DEF = 8;
  localparam int FRACTION_DEF = 8;
  localparam int NUM_CHANNELS = 4;
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W = 16;
  localparam int SMOOTH_W = 17;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int WANTS_W = 4;

  localparam logic [15:0] CUTOFF_RST = 16'd0;
  localparam logic INVERT_RST = 1'b0;
  localparam logic [11:0] BAND_RST = 12'd100;
  localparam logic [3:0] CONFIRM_RST = 4'd3;
  localparam logic [8:0] WEIGHT_RST = 9'd192;
  localparam logic [8:0] WEIGHT_FULL = 9'd256;
  localparam logic [WANTS_W-1:0] WANTS_MAX = 4'd15;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CUTOFF  = 3'd0,
    REG_INVERT  = 3'd1,
    REG_BAND    = 3'd2,
    REG_CONFIRM = 3'd3,
    REG_WEIGHT  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [15:0] cutoff;
    logic        invert;
    logic [11:0] band;
    logic [3:0]  confirm;
    logic [8:0]  weight;
  } cfg_t;

  typedef struct packed {
    logic                night;
    logic                switched;
    logic [SMOOTH_W-1:0] smoothed;
    logic [LEVEL_W-1:0]  raw;
  } result_t;

endpackage

// File: rtl/dnls_lane.sv
// one channel lane: running sum, then floored mean by reciprocal multiply
module dnls_lane #(
  parameter int SAMPLES_PER_CHECK = dnls_pkg::SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          acc,
  input  logic                          last,
  input  logic [dnls_pkg::SAMPLE_W-1:0] sample,
  output logic [dnls_pkg::LEVEL_W-1:0]  mean
);

  localparam int CLOG = $clog2(SAMPLES_PER_CHECK);
  localparam int SW = dnls_pkg::SAMPLE_W + CLOG;
  localparam int SHIFT = SW + CLOG;
  localparam int RW = SW + 2;
  localparam int PW = SW + RW;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(SAMPLES_PER_CHECK) - 64'd1) / 64'(SAMPLES_PER_CHECK);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_FULL);

  logic [SW-1:0] sum;
  logic [SW-1:0] sum_next;
  logic [SW-1:0] total;
  logic [PW-1:0] prod;

  assign sum_next = sum + SW'(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (en && acc) begin
      sum <= last ? '0 : sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && acc && last) begin
      total <= sum_next;
    end
    // exact floor division: sum stays below 2^SW
    if (en) begin
      prod <= PW'(total) * PW'(RECIP);
    end
  end

  assign mean = prod[SHIFT +: dnls_pkg::LEVEL_W];

endmodule

// File: rtl/dnls_merge.sv
// merges lane means into a level, smooths it and runs the debounced mode decision
module dnls_merge #(
  parameter int FRACTION_BITS = dnls_pkg::FRACTION_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   en,
  input  logic                                                   mean_valid,
  input  logic [dnls_pkg::NUM_CHANNELS-1:0][dnls_pkg::LEVEL_W-1:0] means,
  input  dnls_pkg::cfg_t                                         cfg,
  output logic                                                   res_valid,
  output dnls_pkg::result_t                                      res
);

  localparam int AW = dnls_pkg::LEVEL_W + FRACTION_BITS;
  localparam int MW = AW + 11;

  logic                              v3;
  logic                              v4;
  logic [dnls_pkg::LEVEL_W-1:0]      level3;
  logic [dnls_pkg::LEVEL_W-1:0]      level4;
  logic [dnls_pkg::SMOOTH_W-1:0]     smooth4;
  logic [dnls_pkg::LEVEL_W+1:0]      mean_sum;

  logic [AW-1:0]                     avg;
  logic                              seeded;
  logic [AW-1:0]                     avg_base;
  logic [AW-1:0]                     lq;
  logic [AW-1:0]                     avg_next;
  logic signed [AW:0]                diff;
  logic signed [9:0]                 wgt;
  logic signed [MW-1:0]              wprod;
  logic signed [MW-1:0]              delta;
  logic signed [MW-1:0]              avg_sum;

  logic                              night;
  logic [dnls_pkg::WANTS_W-1:0]      day_wants;
  logic [dnls_pkg::WANTS_W-1:0]      night_wants;
  logic                              night_next;
  logic [dnls_pkg::WANTS_W-1:0]      day_wants_next;
  logic [dnls_pkg::WANTS_W-1:0]      night_wants_next;
  logic                              switched;

  logic [15:0]                       low;
  logic [dnls_pkg::SMOOTH_W-1:0]     high;
  logic                              below;
  logic                              above;
  logic                              to_day;
  logic                              to_night;
  logic [3:0]                        need;
  logic [dnls_pkg::WANTS_W-1:0]      day_inc;
  logic [dnls_pkg::WANTS_W-1:0]      night_inc;

  assign mean_sum = 18'(means[0]) + 18'(means[1]) + 18'(means[2]) + 18'(means[3]);

  // moving average as avg + floor(w * (L - avg) / 256)
  assign lq = AW'(level3) << FRACTION_BITS;
  assign avg_base = seeded ? avg : lq;
  assign diff = $signed({1'b0, lq}) - $signed({1'b0, avg_base});
  assign wgt = (cfg.weight > dnls_pkg::WEIGHT_FULL) ? $signed({1'b0, dnls_pkg::WEIGHT_FULL})
                                                     : $signed({1'b0, cfg.weight});
  assign wprod = MW'(diff) * MW'(wgt);
  assign delta = wprod >>> 8;
  assign avg_sum = MW'($signed({1'b0, avg_base})) + delta;
  assign avg_next = avg_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      avg <= '0;
      seeded <= 1'b0;
      night <= 1'b0;
      day_wants <= '0;
      night_wants <= '0;
    end else if (en) begin
      v3 <= mean_valid;
      v4 <= v3;
      if (v3) begin
        avg <= avg_next;
        seeded <= 1'b1;
      end
      if (v4) begin
        night <= night_next;
        day_wants <= day_wants_next;
        night_wants <= night_wants_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level3 <= mean_sum[dnls_pkg::LEVEL_W+1:2];
      level4 <= level3;
      smooth4 <= dnls_pkg::SMOOTH_W'(avg_next[AW-1:FRACTION_BITS]) + 17'd1;
    end
  end

  // thresholds around the cutoff
  assign low = (cfg.cutoff > 16'(cfg.band)) ? cfg.cutoff - 16'(cfg.band) : 16'd0;
  assign high = 17'(cfg.cutoff) + 17'(cfg.band);
  assign below = smooth4 < 17'(low);
  assign above = smooth4 > high;
  assign to_night = !night && (cfg.invert ? above : below);
  assign to_day = night && (cfg.invert ? below : above);
  assign need = (cfg.confirm == 4'd0) ? 4'd1 : cfg.confirm;
  assign day_inc = (day_wants == dnls_pkg::WANTS_MAX) ? dnls_pkg::WANTS_MAX : day_wants + 4'd1;
  assign night_inc = (night_wants == dnls_pkg::WANTS_MAX) ? dnls_pkg::WANTS_MAX
                                                           : night_wants + 4'd1;

  always_comb begin
    night_next = night;
    switched = 1'b0;
    day_wants_next = '0;
    night_wants_next = '0;
    if (to_day) begin
      day_wants_next = day_inc;
    end else if (to_night) begin
      night_wants_next = night_inc;
    end
    if (night && day_wants_next >= need) begin
      night_next = 1'b0;
      switched = 1'b1;
      day_wants_next = '0;
      night_wants_next = '0;
    end else if (!night && night_wants_next >= need) begin
      night_next = 1'b1;
      switched = 1'b1;
      day_wants_next = '0;
      night_wants_next = '0;
    end
  end

  assign res_valid = v4;
  assign res.night = night_next;
  assign res.switched = switched;
  assign res.smoothed = smooth4;
  assign res.raw = level4;

endmodule

// File: rtl/day_night_light_switch.sv
// top level of the day/night light switch: config registers, lanes, merge and output skid
//
// Input channel: one transaction carries one set of four light-sensor samples
// (channel_zero..channel_three). A new set is taken every clock cycle while
// in_ready is high. Every SAMPLES_PER_CHECK-th set closes a check and yields
// exactly one result transaction (night_active, mode_switched, smoothed_level,
// raw_level); the other sets yield nothing.
// Result path: a check's last sample set goes through the lane sum, reciprocal
// multiply, level add and moving-average multiply, then the decision into the
// output register.
// Throughput: one sample set per cycle while in_ready is high.
// Config channel: cfg_index selects the register (0 cutoff, 1 invert, 2 band,
// 3 confirmations, 4 weight), cfg_data carries the value; always ready, and
// indices past the list are dropped. Write only while the block is idle.
// Reset: sums, sample count, average, mode (day) and counters are cleared and
// the registers take their defaults.
// Stall: a skid register holds one extra result while out_ready is low; once it
// is full in_ready drops until the output drains.
module day_night_light_switch #(
  parameter int SAMPLES_PER_CHECK = dnls_pkg::SAMPLES_DEF,
  parameter int FRACTION_BITS = dnls_pkg::FRACTION_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dnls_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dnls_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dnls_pkg::SAMPLE_W-1:0]      channel_zero,
  input  logic [dnls_pkg::SAMPLE_W-1:0]      channel_one,
  input  logic [dnls_pkg::SAMPLE_W-1:0]      channel_two,
  input  logic [dnls_pkg::SAMPLE_W-1:0]      channel_three,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               night_active,
  output logic                               mode_switched,
  output logic [dnls_pkg::SMOOTH_W-1:0]      smoothed_level,
  output logic [dnls_pkg::LEVEL_W-1:0]       raw_level
);

  localparam int CW = (SAMPLES_PER_CHECK > 1) ? $clog2(SAMPLES_PER_CHECK) : 1;
  localparam logic [CW-1:0] COUNT_LAST = CW'(SAMPLES_PER_CHECK - 1);

  dnls_pkg::cfg_t    cfg;
  dnls_pkg::result_t res;
  dnls_pkg::result_t out_data;
  dnls_pkg::result_t skid_data;
  logic              skid_valid;
  logic              res_valid;
  logic              en;
  logic              acc;
  logic              last;
  logic              v1;
  logic              v2;
  logic [CW-1:0]     count;

  logic [dnls_pkg::NUM_CHANNELS-1:0][dnls_pkg::SAMPLE_W-1:0] samples;
  logic [dnls_pkg::NUM_CHANNELS-1:0][dnls_pkg::LEVEL_W-1:0]  means;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cutoff <= dnls_pkg::CUTOFF_RST;
      cfg.invert <= dnls_pkg::INVERT_RST;
      cfg.band <= dnls_pkg::BAND_RST;
      cfg.confirm <= dnls_pkg::CONFIRM_RST;
      cfg.weight <= dnls_pkg::WEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dnls_pkg::REG_CUTOFF:  cfg.cutoff <= cfg_data;
        dnls_pkg::REG_INVERT:  cfg.invert <= cfg_data[0];
        dnls_pkg::REG_BAND:    cfg.band <= cfg_data[11:0];
        dnls_pkg::REG_CONFIRM: cfg.confirm <= cfg_data[3:0];
        dnls_pkg::REG_WEIGHT:  cfg.weight <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances while the skid register is free
  assign en = !skid_valid;
  assign in_ready = en;
  assign acc = in_valid && in_ready;
  assign last = (count == COUNT_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      if (acc) begin
        count <= last ? '0 : count + CW'(1);
      end
      v1 <= acc && last;
      v2 <= v1;
    end
  end

  assign samples = {channel_three, channel_two, channel_one, channel_zero};

  for (genvar i = 0; i < dnls_pkg::NUM_CHANNELS; i++) begin : g_lane
    dnls_lane #(
      .SAMPLES_PER_CHECK(SAMPLES_PER_CHECK)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .acc    (acc),
      .last   (last),
      .sample (samples[i]),
      .mean   (means[i])
    );
  end

  dnls_merge #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .mean_valid (v2),
    .means      (means),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (en) begin
      if (out_valid && !out_ready) begin
        skid_valid <= res_valid;
      end else begin
        out_valid <= res_valid;
      end
    end else if (out_ready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (out_valid && !out_ready) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end else if (out_ready) begin
      out_data <= skid_data;
    end
  end

  assign night_active = out_data.night;
  assign mode_switched = out_data.switched;
  assign smoothed_level = out_data.smoothed;
  assign raw_level = out_data.raw;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a pending output");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid filled while the output was not stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_LAST)
    else $error("sample count past the check length");

endmodule

// File: bench/day_night_light_switch_tb.sv
// self-checking testbench for the day/night light switch with a built-in mode tracker
`timescale 1ns / 1ps

module day_night_light_switch_tb;
  import dnls_pkg::*;

  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int WEIGHT_SHIFT = 8;
  localparam int AVG_W = LEVEL_W + FRACTION_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT = 4000;

  // tracks sums, moving average and debounce, and queues the expected check results
  class switch_tracker;
    cfg_t settings;
    logic [SAMPLE_W+2:0] sums [NUM_CHANNELS];
    int unsigned set_count;
    logic [AVG_W-1:0] average;
    bit seeded;
    bit night;
    logic [WANTS_W-1:0] day_wants;
    logic [WANTS_W-1:0] night_wants;
    result_t pending_checks [$];
    int mismatches;

    function new();
      settings.cutoff = CUTOFF_RST;
      settings.invert = INVERT_RST;
      settings.band = BAND_RST;
      settings.confirm = CONFIRM_RST;
      settings.weight = WEIGHT_RST;
      foreach (sums[i]) sums[i] = '0;
      set_count = 0;
      average = '0;
      seeded = 1'b0;
      night = 1'b0;
      day_wants = '0;
      night_wants = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_CUTOFF: settings.cutoff = data;
        REG_INVERT: settings.invert = data[0];
        REG_BAND: settings.band = data[11:0];
        REG_CONFIRM: settings.confirm = data[3:0];
        REG_WEIGHT: settings.weight = data[8:0];
        default: ;
      endcase
    endfunction

    function void take_samples(logic [SAMPLE_W-1:0] c0, logic [SAMPLE_W-1:0] c1,
                               logic [SAMPLE_W-1:0] c2, logic [SAMPLE_W-1:0] c3);
      logic [SAMPLE_W-1:0] ch [NUM_CHANNELS];
      int unsigned total, level, low_mark, high_mark, w, need;
      longint unsigned level_q, mix;
      logic [SMOOTH_W-1:0] smooth;
      bit day_req, night_req, switched;
      result_t r;
      ch[0] = c0;
      ch[1] = c1;
      ch[2] = c2;
      ch[3] = c3;
      foreach (sums[i]) sums[i] = sums[i] + ch[i];
      set_count++;
      if (set_count < SAMPLES_DEF) return;

      total = 0;
      foreach (sums[i]) begin
        total += sums[i] / SAMPLES_DEF;
        sums[i] = '0;
      end
      set_count = 0;
      level = total / NUM_CHANNELS;

      level_q = longint'(level) << FRACTION_DEF;
      if (!seeded) begin
        average = level_q;
        seeded = 1'b1;
      end
      w = (settings.weight > WEIGHT_FULL) ? WEIGHT_FULL : settings.weight;
      mix = (w * level_q + (WEIGHT_FULL - w) * average) >> WEIGHT_SHIFT;
      average = mix;
      smooth = (average >> FRACTION_DEF) + 1;

      low_mark = (settings.cutoff > settings.band) ? settings.cutoff - settings.band : 0;
      high_mark = int'(settings.cutoff) + int'(settings.band);

      day_req = 1'b0;
      night_req = 1'b0;
      if (!settings.invert) begin
        if (!night) night_req = smooth < low_mark;
        else day_req = smooth > high_mark;
      end else begin
        if (!night) night_req = smooth > high_mark;
        else day_req = smooth < low_mark;
      end

      if (day_req) begin
        day_wants = (day_wants == WANTS_MAX) ? WANTS_MAX : day_wants + 1'b1;
        night_wants = '0;
      end else if (night_req) begin
        night_wants = (night_wants == WANTS_MAX) ? WANTS_MAX : night_wants + 1'b1;
        day_wants = '0;
      end else begin
        day_wants = '0;
        night_wants = '0;
      end

      // zero confirmations behaves like one
      need = (settings.confirm == 0) ? 1 : settings.confirm;
      switched = 1'b0;
      if (night && day_wants >= need) begin
        night = 1'b0;
        switched = 1'b1;
        day_wants = '0;
        night_wants = '0;
      end else if (!night && night_wants >= need) begin
        night = 1'b1;
        switched = 1'b1;
        day_wants = '0;
        night_wants = '0;
      end

      r.night = night;
      r.switched = switched;
      r.smoothed = smooth;
      r.raw = level[LEVEL_W-1:0];
      pending_checks.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_checks.size() == 0) begin
        $error("result transaction with nothing expected: raw_level %0d", got.raw);
        mismatches++;
        return;
      end
      want = pending_checks.pop_front();
      if (got.night !== want.night) begin
        $error("night_active: expected %0d, actual %0d", want.night, got.night);
        mismatches++;
      end
      if (got.switched !== want.switched) begin
        $error("mode_switched: expected %0d, actual %0d", want.switched, got.switched);
        mismatches++;
      end
      if (got.smoothed !== want.smoothed) begin
        $error("smoothed_level: expected %0d, actual %0d", want.smoothed, got.smoothed);
        mismatches++;
      end
      if (got.raw !== want.raw) begin
        $error("raw_level: expected %0d, actual %0d", want.raw, got.raw);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [SAMPLE_W-1:0] channel_zero;
  logic [SAMPLE_W-1:0] channel_one;
  logic [SAMPLE_W-1:0] channel_two;
  logic [SAMPLE_W-1:0] channel_three;
  logic out_valid;
  logic out_ready;
  logic night_active;
  logic mode_switched;
  logic [SMOOTH_W-1:0] smoothed_level;
  logic [LEVEL_W-1:0] raw_level;

  switch_tracker tracker;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;

  day_night_light_switch dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .channel_zero(channel_zero),
    .channel_one(channel_one),
    .channel_two(channel_two),
    .channel_three(channel_three),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .night_active(night_active),
    .mode_switched(mode_switched),
    .smoothed_level(smoothed_level),
    .raw_level(raw_level)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random backpressure, or one long hold-off when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request <= 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // results are checked before this edge's input is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        tracker.check_result({night_active, mode_switched, smoothed_level, raw_level});
      if (in_valid && in_ready)
        tracker.take_samples(channel_zero, channel_one, channel_two, channel_three);
      if (cfg_valid && cfg_ready)
        tracker.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("** day_night_light_switch: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_set(input logic [SAMPLE_W-1:0] c0, input logic [SAMPLE_W-1:0] c1,
                          input logic [SAMPLE_W-1:0] c2, input logic [SAMPLE_W-1:0] c3);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    channel_zero <= c0;
    channel_one <= c1;
    channel_two <= c2;
    channel_three <= c3;
    do @(posedge clk); while (!in_ready);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic put_reg(input logic [CFG_INDEX_W-1:0] index,
                         input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // high bits above each register's width are filled with noise
  task automatic apply_settings(input cfg_t s, input bit stray_write);
    put_reg(REG_CUTOFF, s.cutoff);
    put_reg(REG_INVERT, {15'($urandom), s.invert});
    put_reg(REG_BAND, {4'($urandom), s.band});
    put_reg(REG_CONFIRM, {12'($urandom), s.confirm});
    put_reg(REG_WEIGHT, {7'($urandom), s.weight});
    if (stray_write) put_reg(REG_WEIGHT + $urandom_range(1, 3), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // stop offering sets and wait until every check has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_checks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // light level wanders around the thresholds, with jumps to the rails and stray readings
  task automatic run_phase(input cfg_t s, input int sets, input int tx_pct, input int rx_pct,
                           input bit squeeze, input bit stray_write);
    int anchor, spread, reach, x;
    logic [SAMPLE_W-1:0] v [NUM_CHANNELS];
    settle();
    apply_settings(s, stray_write);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    if (squeeze) hold_request <= 1'b1;
    reach = int'(s.band) + 2000;
    anchor = s.cutoff;
    spread = 0;
    for (int k = 0; k < sets; k++) begin
      if (k % SAMPLES_DEF == 0 && $urandom_range(99) < 35) begin
        case ($urandom_range(9))
          0: anchor = 0;
          1: anchor = SAMPLE_MAX;
          2, 3: anchor = $urandom_range(SAMPLE_MAX);
          default: anchor = int'(s.cutoff) + int'($urandom_range(2 * reach)) - reach;
        endcase
        spread = 500 * $urandom_range(3);
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        x = anchor + int'($urandom_range(2 * spread)) - spread;
        if ($urandom_range(99) < 12) x = $urandom_range(SAMPLE_MAX);
        v[c] = (x < 0) ? '0 : (x > SAMPLE_MAX) ? SAMPLE_MAX : x[SAMPLE_W-1:0];
      end
      send_set(v[0], v[1], v[2], v[3]);
    end
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    channel_zero = '0;
    channel_one = '0;
    channel_two = '0;
    channel_three = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: dark check seeds the average
    for (int k = 0; k < SAMPLES_DEF; k++) send_set('0, '0, '0, '0);
    settle();
    // wide band, zero confirmations, full weight
    apply_settings({16'd32768, 1'b0, 12'd4095, 4'd0, 9'd256}, 1'b0);
    for (int k = 0; k < SAMPLES_DEF; k++)
      send_set(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    for (int k = 0; k < SAMPLES_DEF; k++)
      send_set(k[0] ? 16'hFFFF : 16'h0000, 16'hAAAA, 16'h5555, 16'h0000);

    run_phase({16'd30000, 1'b0, 12'd2000, 4'd3, 9'd192}, 176, 36, 36, 1'b0, 1'b0);
    // weight above full scale, max confirmations; receiver holds off while sets stream in
    run_phase({16'd65535, 1'b1, 12'd4095, 4'd15, 9'd511}, 176, 0, 36, 1'b1, 1'b0);
    // weight zero freezes the average; no idling on either side
    run_phase({16'd0, 1'b1, 12'd0, 4'd1, 9'd0}, 176, 0, 0, 1'b0, 1'b1);
    run_phase({16'd20000, 1'b0, 12'd0, 4'd2, 9'd64}, 176, 36, 36, 1'b0, 1'b1);
    repeat (4)
      run_phase({16'($urandom), 1'($urandom), 12'($urandom), 4'($urandom), 9'($urandom)},
                176, 36, 36, 1'b0, 1'($urandom));
    settle();

    if (tracker.mismatches == 0) $display("** day_night_light_switch: PASSED **");
    else $display("** day_night_light_switch: FAILED **");
    $finish;
  end

endmodule

// File: files.f
rtl/dnls_pkg.sv
rtl/dnls_lane.sv
rtl/dnls_merge.sv
rtl/day_night_light_switch.sv
bench/day_night_light_switch_tb.sv
